>>> hdl/upd_pkg.sv
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] PCT_CHAR    = 8'h25;
    localparam int         QUEUE_DEPTH = 4;
    localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int         QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int         MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef enum logic [1:0] {
        LVL_NONE  = 2'd0,
        LVL_PCT   = 2'd1,
        LVL_DIGIT = 2'd2
    } level_t;

    // one queued command: up to three result bytes of one input transaction
    typedef struct packed {
        logic [1:0]                       count;
        logic [MAX_RESULTS-1:0][7:0]      bytes;
        logic                             last;
    } cmd_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] ch);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            h.val = 4'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            h.val = 4'(ch - 8'h41 + 8'd10);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            h.val = 4'(ch - 8'h61 + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

>>> hdl/upd_front.sv
`timescale 1ns / 1ps

module upd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  upd_pkg::in_item_t in_data,
    output logic              in_stall,
    input  logic              queue_full,
    output logic              push_valid,
    output upd_pkg::cmd_t     push_data
);

    upd_pkg::level_t level_reg, level_next;
    logic [7:0]      held_reg, held_next;

    logic         accept;
    logic [7:0]   b;
    logic         last;
    logic         plain_hold;
    upd_pkg::hex_t cur_hex;
    upd_pkg::hex_t held_hex;

    assign b          = in_data.in_byte;
    assign last       = in_data.in_last;
    assign cur_hex    = upd_pkg::hex_digit(b);
    assign held_hex   = upd_pkg::hex_digit(held_reg);
    assign plain_hold = (b == upd_pkg::PCT_CHAR) && !last;
    assign in_stall   = queue_full;
    assign accept     = in_valid && !queue_full;

    // next state
    always_comb
    begin
        level_next = level_reg;
        held_next  = held_reg;
        if (accept) begin
            held_next = held_reg;
            unique case (level_reg)
                upd_pkg::LVL_PCT:
                begin
                    if (cur_hex.ok && !last) begin
                        level_next = upd_pkg::LVL_DIGIT;
                        held_next  = b;
                    end else begin
                        level_next = plain_hold ? upd_pkg::LVL_PCT : upd_pkg::LVL_NONE;
                    end
                end
                upd_pkg::LVL_DIGIT:
                begin
                    held_next = 8'd0;
                    if (cur_hex.ok && held_hex.ok) begin
                        level_next = upd_pkg::LVL_NONE;
                    end else begin
                        level_next = plain_hold ? upd_pkg::LVL_PCT : upd_pkg::LVL_NONE;
                    end
                end
                default:
                begin
                    level_next = plain_hold ? upd_pkg::LVL_PCT : upd_pkg::LVL_NONE;
                end
            endcase
        end
    end

    // results of the transaction
    always_comb
    begin
        push_data.count = 2'd0;
        push_data.bytes = '0;
        push_data.last  = last;
        unique case (level_reg)
            upd_pkg::LVL_PCT:
            begin
                if (!(cur_hex.ok && !last)) begin
                    push_data.bytes[0] = upd_pkg::PCT_CHAR;
                    push_data.bytes[1] = b;
                    push_data.count    = plain_hold ? 2'd1 : 2'd2;
                end
            end
            upd_pkg::LVL_DIGIT:
            begin
                if (cur_hex.ok && held_hex.ok) begin
                    push_data.bytes[0] = {held_hex.val, cur_hex.val};
                    push_data.count    = 2'd1;
                end else begin
                    push_data.bytes[0] = upd_pkg::PCT_CHAR;
                    push_data.bytes[1] = held_reg;
                    push_data.bytes[2] = b;
                    push_data.count    = plain_hold ? 2'd2 : 2'd3;
                end
            end
            default:
            begin
                push_data.bytes[0] = b;
                push_data.count    = plain_hold ? 2'd0 : 2'd1;
            end
        endcase
        push_valid = accept && (push_data.count != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            level_reg <= upd_pkg::LVL_NONE;
            held_reg  <= 8'd0;
        end else begin
            level_reg <= level_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> hdl/upd_queue.sv
`timescale 1ns / 1ps

module upd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  upd_pkg::cmd_t push_data,
    output logic          full,
    output logic          head_valid,
    output upd_pkg::cmd_t head_data,
    input  logic          pop
);

    upd_pkg::cmd_t                    entry_reg [upd_pkg::QUEUE_DEPTH];
    logic [upd_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [upd_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [upd_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full       = (count_reg == upd_pkg::QCNT_W'(upd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/upd_back.sv
`timescale 1ns / 1ps

module upd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  upd_pkg::cmd_t      head_data,
    output logic               pop,
    output logic               out_valid,
    output upd_pkg::out_item_t out_data,
    input  logic               out_stall
);

    logic [1:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    upd_pkg::out_item_t out_reg, out_next;
    logic               load;
    logic               final_byte;
    logic [7:0]         sel_byte;

    assign load       = head_valid && (!out_valid_reg || !out_stall);
    assign final_byte = (idx_reg == head_data.count - 2'd1);
    assign pop        = load && final_byte;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = head_data.bytes[0];
            2'd1:    sel_byte = head_data.bytes[1];
            2'd2:    sel_byte = head_data.bytes[2];
            default: sel_byte = head_data.bytes[0];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_next.out_byte = sel_byte;
            out_next.out_last = head_data.last && final_byte;
            out_valid_next    = 1'b1;
            idx_next          = final_byte ? 2'd0 : idx_reg + 2'd1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> hdl/url_percent_decoder_unit.sv
`timescale 1ns / 1ps

// streaming url percent decoder
// input channel: in_valid / in_stall / in_data, one encoded character per
//   transaction, in_last set on the final character of a string
// output channel: out_valid / out_stall / out_data, one decoded or literal
//   character per transaction, out_last set on the final one of a string
// a front stage classifies each character against the held '%' and hex
//   digit and queues its 1 to 3 result bytes, if any, as one entry in a
//   4-entry queue; a back stage drains entries into an output register,
//   one byte per cycle while out_stall is low; the results of an accepted
//   input are registered in the queue, then in the output register
// throughput: one input per cycle while each input gives at most one
//   result and out_stall is low; an input that gives k results holds the
//   back stage for k bytes; the queue absorbs that until in_stall rises
// out_stall holds the output register; the queue keeps filling and in_stall
//   goes high only when all 4 entries are taken
// reset clears the held '%' and digit, empties the queue and drops out_valid

module url_percent_decoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  upd_pkg::in_item_t  in_data,
    output logic               in_stall,
    output logic               out_valid,
    output upd_pkg::out_item_t out_data,
    input  logic               out_stall
);

    logic          push_valid;
    upd_pkg::cmd_t push_data;
    logic          queue_full;
    logic          head_valid;
    upd_pkg::cmd_t head_data;
    logic          pop;

    upd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .in_stall   (in_stall),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    upd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    upd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_data   (out_data),
        .out_stall  (out_stall)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES = 150;
    localparam int WATCH_LIMIT = 2000;
    localparam int TAIL_ITEMS  = 40;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    upd_pkg::in_item_t  in_data   = '0;
    logic               in_stall;
    logic               out_valid;
    upd_pkg::out_item_t out_data;
    logic               out_stall = 1'b0;

    upd_pkg::in_item_t  char_q[$];
    upd_pkg::out_item_t decoded_q[$];

    // predicted decoder state
    upd_pkg::level_t dec_lvl  = upd_pkg::LVL_NONE;
    logic [7:0]      dec_held = 8'h00;

    int   n_chars     = 0;
    int   n_strings   = 0;
    int   n_sent      = 0;
    int   n_checked   = 0;
    int   n_errors    = 0;
    int   n_in_held   = 0;
    int   send_gap    = 0;
    int   recv_gap    = 0;
    int   hold_left   = 0;
    int   idle_cycles = 0;
    bit   hold_done   = 1'b0;
    logic holding     = 1'b0;
    logic tail_calm   = 1'b0;
    logic [15:0] cyc  = '0;

    url_percent_decoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cyc <= cyc + 16'd1;
    end

    // {is hex, value}
    function automatic logic [4:0] nibble_of(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
            return {1'b1, 4'(ch - "0")};
        if (ch >= "A" && ch <= "F")
            return {1'b1, 4'(ch - "A" + 8'd10)};
        if (ch >= "a" && ch <= "f")
            return {1'b1, 4'(ch - "a" + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10)
            return 8'("0" + k);
        if (k < 16)
            return 8'("A" + k - 10);
        return 8'("a" + k - 16);
    endfunction

    task automatic decode_step(input upd_pkg::in_item_t it);
        logic [7:0]         res [3];
        logic [4:0]         cur;
        logic [4:0]         hi;
        upd_pkg::out_item_t r;
        int                 n;
        bit                 fresh;
        n     = 0;
        fresh = 1'b0;
        cur   = nibble_of(it.in_byte);
        case (dec_lvl)
            upd_pkg::LVL_DIGIT:
            begin
                hi      = nibble_of(dec_held);
                dec_lvl = upd_pkg::LVL_NONE;
                if (cur[4] && hi[4])
                begin
                    res[0] = {hi[3:0], cur[3:0]};
                    n      = 1;
                end
                else
                begin
                    res[0] = upd_pkg::PCT_CHAR;
                    res[1] = dec_held;
                    n      = 2;
                    fresh  = 1'b1;
                end
                dec_held = 8'h00;
            end
            upd_pkg::LVL_PCT:
            begin
                if (cur[4] && !it.in_last)
                begin
                    dec_lvl  = upd_pkg::LVL_DIGIT;
                    dec_held = it.in_byte;
                end
                else
                begin
                    res[0]  = upd_pkg::PCT_CHAR;
                    n       = 1;
                    dec_lvl = upd_pkg::LVL_NONE;
                    fresh   = 1'b1;
                end
            end
            default:
            begin
                dec_lvl = upd_pkg::LVL_NONE;
                fresh   = 1'b1;
            end
        endcase
        // byte examined again with nothing held
        if (fresh)
        begin
            if (it.in_byte == upd_pkg::PCT_CHAR && !it.in_last)
                dec_lvl = upd_pkg::LVL_PCT;
            else
            begin
                res[n] = it.in_byte;
                n++;
            end
        end
        if (it.in_last)
            dec_lvl = upd_pkg::LVL_NONE;
        for (int k = 0; k < n; k++)
        begin
            r.out_byte = res[k];
            r.out_last = it.in_last && (k == n - 1);
            decoded_q.push_back(r);
        end
    endtask

    task automatic push_char(input logic [7:0] b, input logic last);
        upd_pkg::in_item_t it;
        it.in_byte = b;
        it.in_last = last;
        char_q.push_back(it);
        n_chars++;
        if (last)
            n_strings++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin : drive
            bit free;
            bit calm;
            free = !in_valid;
            if (in_valid && !in_stall)
            begin
                decode_step(in_data);
                n_sent++;
                free = 1'b1;
            end
            if (in_valid && in_stall)
                n_in_held++;
            calm = tail_calm || holding || cyc[6:5] == 2'b11;
            if (free)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(1, 10) - 1;
                    in_valid <= 1'b0;
                end
                else if (char_q.size() > 0)
                begin
                    in_data  <= char_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            tail_calm <= char_q.size() < TAIL_ITEMS;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin : check
            upd_pkg::out_item_t want;
            if (out_valid && !out_stall)
            begin
                n_checked++;
                if (decoded_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("tb_top: unexpected result byte=%02h last=%0b",
                                 out_data.out_byte, out_data.out_last);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_data.out_byte !== want.out_byte ||
                        out_data.out_last !== want.out_last)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"tb_top: result %0d expected byte=%02h last=%0b,",
                                      " got byte=%02h last=%0b"},
                                     n_checked, want.out_byte, want.out_last,
                                     out_data.out_byte, out_data.out_last);
                    end
                end
            end
            // one long hold-off so the internal queue fills and the input stalls
            if (!hold_done && n_checked >= 80)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (!tail_calm && cyc[6:5] != 2'b01 && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(1, 10) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
            holding <= hold_left > 0;
        end
    end

    // watchdog on transactions in either direction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("tb_top: no transaction for %0d cycles", WATCH_LIMIT);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] str_q[$];
        int         ntok;

        // directed strings
        push_text("%aF");
        push_text("%00");
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b1);
        push_text("%%41");
        push_text("%G");
        push_text("%4Z");
        push_text("%");
        push_text("%4");
        push_text("%4%");

        // random strings built mostly from valid escapes
        while (char_q.size() < 270)
        begin
            str_q.delete();
            ntok = $urandom_range(1, 5);
            for (int t = 0; t < ntok; t++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        str_q.push_back(upd_pkg::PCT_CHAR);
                        str_q.push_back(rand_hex_char());
                        str_q.push_back(rand_hex_char());
                    end
                    4, 5, 6:
                        str_q.push_back(8'($urandom_range(0, 255)));
                    7:
                    begin
                        str_q.push_back(upd_pkg::PCT_CHAR);
                        str_q.push_back(8'($urandom_range(0, 255)));
                    end
                    8:
                    begin
                        str_q.push_back(upd_pkg::PCT_CHAR);
                        str_q.push_back(rand_hex_char());
                    end
                    default:
                        str_q.push_back(upd_pkg::PCT_CHAR);
                endcase
            end
            for (int i = 0; i < str_q.size(); i++)
                push_char(str_q[i], i == str_q.size() - 1);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (char_q.size() > 0 || in_valid)
            @(posedge clk);
        while (decoded_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (decoded_q.size() > 0)
        begin
            n_errors += decoded_q.size();
            $display("tb_top: %0d results never arrived", decoded_q.size());
        end
        $display("tb_top: %0d characters in %0d strings, %0d results checked, %0d errors",
                 n_sent, n_strings, n_checked, n_errors);
        $display("tb_top: output held off %0d cycles once, input stalled %0d cycles",
                 HOLD_CYCLES, n_in_held);
        if (n_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
hdl/upd_pkg.sv
hdl/upd_front.sv
hdl/upd_queue.sv
hdl/upd_back.sv
hdl/url_percent_decoder_unit.sv
tb/sv/tb_top.sv
